[src/sha1dg_pkg.sv]
// Package for the SHA-1 digest block with reference check.
// Holds constants, the item type (also the queue entry type) and the state type.
// No dependencies.
package sha1dg_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 55;

    localparam logic [1:0] CFG_REF_HIGH   = 2'd0;
    localparam logic [1:0] CFG_REF_MIDDLE = 2'd1;
    localparam logic [1:0] CFG_REF_LOW    = 2'd2;
    localparam logic [1:0] CFG_REF_LOADED = 2'd3;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

endpackage

[src/sha1dg_front.sv]
// Front part: accepts input requests into a short queue.
// Depends on sha1dg_pkg.
module sha1dg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha1dg_pkg::t_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output sha1dg_pkg::t_item   o_item
);
    import sha1dg_pkg::*;

    t_item r_q [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
endmodule

[src/sha1dg_back.sv]
// Back part: block buffer, padding, one SHA-1 round per cycle, compare.
// Depends on sha1dg_pkg.
module sha1dg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha1dg_pkg::t_item   i_item,
    input  logic [63:0]         i_ref_high,
    input  logic [63:0]         i_ref_middle,
    input  logic [31:0]         i_ref_low,
    input  logic                i_ref_loaded,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [159:0]        o_digest,
    output logic                o_match,
    output logic                o_status
);
    import sha1dg_pkg::*;

    t_state r_st, n_st;
    logic [31:0] r_h [5];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_rnd;
    logic [5:0]  r_idx;
    logic [63:0] r_len;
    logic        r_ovf, r_fin, r_two, r_end, r_lflag;
    logic [31:0] r_lw [5];
    logic [159:0] r_dig;
    logic        r_match, r_status;

    logic [31:0] f, k, t, wn, wr;
    logic [63:0] len_n;
    logic [159:0] chain, refv, sumv;

    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d; k = K3;
        end
        wr = r_w[0];
        t = {r_a[26:0], r_a[31:27]} + f + r_e + wr + k;
        wn = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        wn = {wn[30:0], wn[31]};
        len_n = r_len + 64'd8;
        chain = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        sumv = {32'(r_h[0] + r_a), 32'(r_h[1] + r_b), 32'(r_h[2] + r_c),
                32'(r_h[3] + r_d), 32'(r_h[4] + r_e)};
        if (i_ref_loaded) refv = {i_ref_high, i_ref_middle, i_ref_low};
        else if (r_lflag) refv = {r_lw[0], r_lw[1], r_lw[2], r_lw[3], r_lw[4]};
        else refv = chain;
    end

    always_comb begin
        n_w = r_w;
        unique case (r_st)
            ST_IDLE: if (i_valid && i_item.has_byte && !r_ovf) begin
                n_w[r_idx[5:2]][5'(24 - 8 * r_idx[1:0]) +: 8] = i_item.data_byte;
            end
            ST_PAD: begin
                for (int i = 0; i < 16; i++) begin
                    if (r_two || 6'(i * 4) > r_idx) begin
                        n_w[i] = '0;
                    end else if (6'(i * 4 + 3) >= r_idx) begin
                        n_w[i][5'(24 - 8 * r_idx[1:0]) +: 8] = PAD_BYTE;
                        for (int j = 0; j < 4; j++)
                            if (2'(j) > r_idx[1:0]) n_w[i][5'(24 - 8 * j) +: 8] = '0;
                    end
                end
                if (r_two || r_idx <= 6'(LEN_POS)) begin
                    n_w[14] = r_len[63:32];
                    n_w[15] = r_len[31:0];
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) n_w[i] = r_w[i + 1];
                n_w[15] = wn;
            end
            default: begin end
        endcase
    end

    assign o_ready  = (r_st == ST_IDLE);
    assign o_valid  = (r_st == ST_OUT);
    assign o_digest = r_dig;
    assign o_match  = r_match;
    assign o_status = r_status;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_valid) begin
                if (i_item.has_byte && !r_ovf && r_idx == 6'd63) n_st = ST_ROUND;
                else if (i_item.last) n_st = (r_ovf || (i_item.has_byte &&
                    len_n == 64'd0)) ? ST_OUT : ST_PAD;
            end
            ST_ROUND: if (r_rnd == 7'd79) n_st = ST_ADD;
            ST_ADD: begin
                if (r_end || (r_fin && r_ovf)) n_st = ST_OUT;
                else if (r_fin || r_two) n_st = ST_PAD;
                else n_st = ST_IDLE;
            end
            ST_PAD:   n_st = ST_ROUND;
            ST_OUT:   if (i_ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (r_st == ST_OUT && i_ready && !r_status && !i_ref_loaded && !r_lflag) begin
            for (int i = 0; i < 5; i++) r_lw[i] <= r_h[i];
        end
        if (r_st == ST_ROUND) begin
            r_a <= t; r_b <= r_a; r_c <= {r_b[1:0], r_b[31:2]}; r_d <= r_c; r_e <= r_d;
        end else begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end
        r_rnd <= (r_st == ST_ROUND) ? r_rnd + 7'd1 : 7'd0;
        if (!i_rst_n) begin
            r_h <= '{H0, H1, H2, H3, H4};
            r_idx <= '0; r_len <= '0; r_ovf <= 1'b0; r_fin <= 1'b0; r_end <= 1'b0;
            r_two <= 1'b0; r_lflag <= 1'b0; r_status <= 1'b0; r_match <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: if (i_valid) begin
                    if (i_item.has_byte && !r_ovf) begin
                        r_idx <= r_idx + 6'd1;
                        r_len <= len_n;
                        if (len_n == 64'd0) r_ovf <= 1'b1;
                    end
                    r_fin <= i_item.last;
                    if (i_item.last && (r_ovf || (i_item.has_byte && len_n == 64'd0))) begin
                        r_status <= 1'b1; r_match <= 1'b0; r_dig <= '0;
                    end
                end
                ST_ADD: begin
                    r_h[0] <= sumv[159:128]; r_h[1] <= sumv[127:96];
                    r_h[2] <= sumv[95:64];   r_h[3] <= sumv[63:32];
                    r_h[4] <= sumv[31:0];
                    if (r_end) begin
                        r_status <= 1'b0;
                        r_match <= (sumv == refv) || (!i_ref_loaded && !r_lflag);
                        r_dig <= sumv;
                        r_end <= 1'b0;
                    end
                end
                ST_PAD: begin
                    if (r_two) begin
                        r_two <= 1'b0;
                        r_end <= 1'b1;
                    end else if (r_idx > 6'(LEN_POS)) begin
                        r_two <= 1'b1;
                        r_fin <= 1'b0;
                    end else begin
                        r_fin <= 1'b0;
                        r_end <= 1'b1;
                    end
                end
                ST_OUT: if (i_ready) begin
                    if (!r_status && !i_ref_loaded) r_lflag <= 1'b1;
                    r_h <= '{H0, H1, H2, H3, H4};
                    r_idx <= '0; r_len <= '0; r_ovf <= 1'b0; r_fin <= 1'b0;
                end
                default: begin end
            endcase
        end
    end

    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_match) else $error("match on overflow");
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_ROUND && r_rnd == 7'd79 |=> r_st == ST_ADD) else $error("round count");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_PAD |=> r_st == ST_ROUND) else $error("pad not hashed");
endmodule

[src/sha1_digest_with_reference_check_top.sv]
// Channel   Direction  Contents
// s_axis    in         tdata: data_byte[7:0], has_byte[8]; tlast: last
// m_axis    out        tdata: digest_high, digest_middle, digest_low; tuser: match, status
// cfg       in         i_cfg_we, i_cfg_index, i_cfg_data
// Every 64th byte also hashes its block before the next byte is taken.
// A final item takes one or two padded passes before the result, none if the length overflowed.
// Reset is synchronous and active low. A two-entry queue decouples input from hashing.
// A stalled result holds the back part while the queue keeps taking requests.
// Top level of the SHA-1 digest block; depends on sha1dg_pkg, sha1dg_front, sha1dg_back.
module sha1_digest_with_reference_check_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // data_byte[7:0], has_byte[8], zeros
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // digest_high[63:0], digest_middle, digest_low
    output logic [1:0]   m_axis_tuser,   // match[0], status[1]
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import sha1dg_pkg::*;

    t_item in_item, q_item;
    logic q_valid, q_ready, match, status;
    logic [159:0] dig;
    logic [63:0] r_rh, r_rm;
    logic [31:0] r_rl;
    logic r_rld;

    assign in_item = '{data_byte: s_axis_tdata[7:0], has_byte: s_axis_tdata[8],
                       last: s_axis_tlast};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rh <= '0; r_rm <= '0; r_rl <= '0; r_rld <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_HIGH:   r_rh <= i_cfg_data;
                CFG_REF_MIDDLE: r_rm <= i_cfg_data;
                CFG_REF_LOW:    r_rl <= i_cfg_data[31:0];
                CFG_REF_LOADED: r_rld <= i_cfg_data[0];
                default: begin end
            endcase
        end
    end

    sha1dg_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    sha1dg_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_ref_high(r_rh), .i_ref_middle(r_rm), .i_ref_low(r_rl), .i_ref_loaded(r_rld),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_digest(dig), .o_match(match), .o_status(status)
    );

    assign m_axis_tdata = {dig[31:0], dig[95:32], dig[159:96]};
    assign m_axis_tuser = {status, match};
endmodule

[bench/sha1_digest_checker.sv]
`timescale 1ns / 1ps
// Checker for the SHA-1 digest block: watches the byte, digest and register ports,
// predicts each digest with its own hash model and compares field by field.
// Depends on sha1dg_pkg for the register index names and the SHA-1 constants.
module sha1_digest_checker
    import sha1dg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    output int           o_pending,
    output int           o_fail_count
);

    typedef struct packed {
        logic [159:0] digest;
        logic         match;
        logic         status;
    } digest_result_t;

    digest_result_t digests_due[$];

    logic [63:0] ref_high, ref_middle;
    logic [31:0] ref_low;
    logic        ref_loaded;
    logic [31:0] chain[5];
    logic [31:0] block_buf[16];
    logic [31:0] learned[5];
    logic        learned_valid;
    logic [5:0]  byte_pos;
    logic [63:0] bit_count;
    logic        len_overflow;

    initial o_fail_count = 0;
    assign o_pending = digests_due.size();

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void put_byte(int pos, logic [7:0] v);
        block_buf[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
    endfunction

    function automatic void hash_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function automatic void restart_message();
        chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
        byte_pos = 0;
        bit_count = 0;
        len_overflow = 0;
    endfunction

    function automatic void finish_message();
        int pos;
        digest_result_t r;
        logic [31:0] want[5];
        pos = byte_pos;
        put_byte(pos, PAD_BYTE);
        pos++;
        if (pos > 56) begin
            while (pos < 64) put_byte(pos++, 8'h00);
            hash_block();
            pos = 0;
        end
        while (pos < 56) put_byte(pos++, 8'h00);
        for (int i = 0; i < 8; i++) put_byte(56 + i, bit_count[8 * (7 - i) +: 8]);
        hash_block();
        if (ref_loaded) begin
            want[0] = ref_high[63:32]; want[1] = ref_high[31:0];
            want[2] = ref_middle[63:32]; want[3] = ref_middle[31:0];
            want[4] = ref_low;
        end else begin
            if (!learned_valid) begin
                learned = chain;
                learned_valid = 1;
            end
            want = learned;
        end
        r.digest = {chain[4], chain[2], chain[3], chain[0], chain[1]};
        r.match = (want == chain);
        r.status = 0;
        digests_due.push_back(r);
    endfunction

    task automatic report(string what, logic [159:0] got, logic [159:0] exp_val);
        $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, exp_val);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        digest_result_t r;
        if (!i_rst_n) begin
            ref_high = 0; ref_middle = 0; ref_low = 0; ref_loaded = 0;
            learned_valid = 0;
            restart_message();
            digests_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REF_HIGH:   ref_high = i_cfg_data;
                    CFG_REF_MIDDLE: ref_middle = i_cfg_data;
                    CFG_REF_LOW:    ref_low = i_cfg_data[31:0];
                    CFG_REF_LOADED: ref_loaded = i_cfg_data[0];
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (digests_due.size() == 0) begin
                    report("unexpected digest", m_axis_tdata, '0);
                end else begin
                    r = digests_due.pop_front();
                    if (m_axis_tdata[63:0] !== r.digest[63:0])
                        report("digest_high", m_axis_tdata[63:0], r.digest[63:0]);
                    if (m_axis_tdata[127:64] !== r.digest[127:64])
                        report("digest_middle", m_axis_tdata[127:64], r.digest[127:64]);
                    if (m_axis_tdata[159:128] !== r.digest[159:128])
                        report("digest_low", m_axis_tdata[159:128], r.digest[159:128]);
                    if (m_axis_tuser[0] !== r.match)
                        report("match", m_axis_tuser[0], r.match);
                    if (m_axis_tuser[1] !== r.status)
                        report("status", m_axis_tuser[1], r.status);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tdata[8] && !len_overflow) begin
                    put_byte(byte_pos, s_axis_tdata[7:0]);
                    bit_count += 8;
                    if (bit_count == 0) len_overflow = 1;
                    byte_pos++;
                    if (byte_pos == 0) hash_block();
                end
                if (s_axis_tlast) begin
                    if (len_overflow) begin
                        r = '0;
                        r.status = 1;
                        digests_due.push_back(r);
                        restart_message();
                    end else begin
                        finish_message();
                        restart_message();
                    end
                end
            end
        end
    end

endmodule

[bench/tb_sha1_digest_with_reference_check_top.sv]
`timescale 1ns / 1ps
// Testbench top for the SHA-1 digest block: drives byte messages, register writes
// and random stalls, and gives the verdict. Depends on sha1dg_pkg, the block
// and sha1_digest_checker.
module tb_sha1_digest_with_reference_check_top;
    import sha1dg_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = 0;
    logic         s_axis_tlast = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_we = 0;
    logic [1:0]   i_cfg_index = CFG_REF_HIGH;
    logic [63:0]  i_cfg_data = 0;
    int           pending, fail_count;
    int           send_gap_max = 10, recv_gap_max = 10;
    int           idle_cycles = 0, items_sent = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    sha1_digest_with_reference_check_top dut (.*);

    sha1_digest_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            n = $urandom_range(0, recv_gap_max);
            if (n > 0) begin
                m_axis_tready = 0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready = 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(logic [7:0] data, logic has, logic fin);
        int n;
        n = $urandom_range(0, send_gap_max);
        if (n > 0) begin
            s_axis_tvalid = 0;
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = {7'd0, has, data};
        s_axis_tlast = fin;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_reference(logic [63:0] hi, logic [63:0] mid, logic [31:0] lo,
                                 logic loaded);
        drain();
        write_reg(CFG_REF_HIGH, hi);
        write_reg(CFG_REF_MIDDLE, mid);
        write_reg(CFG_REF_LOW, {32'd0, lo});
        write_reg(CFG_REF_LOADED, {63'd0, loaded});
    endtask

    task automatic send_text(string s, logic empty_finish);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1, !empty_finish && i == s.len() - 1);
        if (empty_finish || s.len() == 0)
            send_request(8'($urandom_range(0, 255)), 0, 1);
    endtask

    task automatic random_message();
        int len, pick;
        logic empty_finish;
        pick = $urandom_range(0, 9);
        if (pick < 6) len = $urandom_range(0, 70);
        else if (pick < 8) len = 54 + $urandom_range(0, 11);
        else len = $urandom_range(100, 200);
        empty_finish = (len == 0) || ($urandom_range(0, 3) == 0);
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
        recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) send_request(8'($urandom_range(0, 255)), 0, 0);
            send_request(8'($urandom_range(0, 255)), 1, !empty_finish && i == len - 1);
        end
        if (empty_finish) send_request(8'($urandom_range(0, 255)), 0, 1);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // Nothing loaded: the empty message is learned, then others compare with it.
        send_text("", 1);
        send_text("abc", 0);
        send_request(8'hFF, 0, 0);
        send_text("", 1);
        send_request(8'h00, 1, 0);
        send_request(8'hFF, 1, 1);

        // Pause until every digest is back before loading a reference.
        set_reference(64'hA9993E364706816A, 64'hBA3E25717850C26C, 32'h9CD0D89D, 1);
        send_text("abc", 0);
        send_text("abc", 1);
        send_text("ab", 0);

        set_reference('1, '1, '1, 1);
        while (items_sent < 600) random_message();
        set_reference('0, '0, '0, 1);
        while (items_sent < 1000) random_message();
        set_reference({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 0);
        while (items_sent < 1750) random_message();

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
